// ===== hw/rtl/napc_pkg.sv =====
`timescale 1ns / 1ps

package napc_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Derived widths
    localparam int PIX_W     = 8;
    localparam int CFG_DIM_W = 13;
    localparam int CFG_IDX_W = 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W     = $clog2(MAX_HEIGHT + 1);
    localparam int SUM_W     = PIX_W + 2;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } napc_reg_idx_t;

    // Reset values of the registers
    localparam logic             MODE_RST   = 1'b1;
    localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
    localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);

    // Mode codes
    localparam logic MODE_DECOMPRESS = 1'b0;
    localparam logic MODE_COMPRESS   = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_NE,
        ST_CALC
    } napc_state_t;

    // Which causal neighbors exist for the current pixel
    typedef struct packed {
        logic has_nw;
        logic has_n;
        logic has_ne;
        logic has_w;
    } napc_nbr_t;

    // Map a written width onto 1..MAX_WIDTH
    function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_DIM_W-1:0] v);
        int vi;
        vi = int'(v);
        if (vi == 0)
        begin
            vi = 1;
        end
        else if (vi > MAX_WIDTH)
        begin
            vi = MAX_WIDTH;
        end
        return WID_W'(vi);
    endfunction

    // Map a written height onto 1..MAX_HEIGHT
    function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_DIM_W-1:0] v);
        int vi;
        vi = int'(v);
        if (vi == 0)
        begin
            vi = 1;
        end
        else if (vi > MAX_HEIGHT)
        begin
            vi = MAX_HEIGHT;
        end
        return HGT_W'(vi);
    endfunction

endpackage

// ===== hw/rtl/neighbor_average_predictive_coder_core.sv =====
`timescale 1ns / 1ps

// Channel   Signals                          Direction  Transfer when
// input     in_valid, in_stall, pixel_in     in         in_valid && !in_stall
// output    out_valid, out_stall,            out        out_valid && !out_stall
//           value_out, end_of_frame
// config    cfg_we, cfg_index, cfg_data      in         cfg_we
//
// Each pixel passes through ST_IDLE, ST_READ_NE and ST_CALC: the single read port
// of the line store is used once for the north pixel and once for the
// north-east pixel, then the prediction is formed and the pixel is written back.
// A result waits in the output register; the next pixel is taken meanwhile,
// and only ST_CALC waits, while that register is full and out_stall is high.
// Reset restores the register defaults and starts a new frame; the line store
// is not cleared, since each row only reads what the row above wrote.

module neighbor_average_predictive_coder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [napc_pkg::PIX_W-1:0]          pixel_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [napc_pkg::PIX_W-1:0]          value_out,
    output logic                                end_of_frame,
    input  logic                                cfg_we,
    input  logic [napc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [napc_pkg::CFG_DIM_W-1:0]      cfg_data
);
    import napc_pkg::*;

    napc_state_t        state_reg, state_next;
    logic               mode_reg;
    logic [WID_W-1:0]   width_reg;
    logic [HGT_W-1:0]   height_reg;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PIX_W-1:0]   west_reg, west_next;
    logic [PIX_W-1:0]   nw_reg, nw_next;
    logic [PIX_W-1:0]   x_reg;
    logic [PIX_W-1:0]   n_reg;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   value_out_reg;
    logic               eof_reg;

    logic               in_xfer;
    logic               fire;
    logic               cfg_hit;
    logic               ram_re;
    logic [COL_W-1:0]   ram_raddr;
    logic [PIX_W-1:0]   ram_rdata;
    logic [WID_W-1:0]   col_inc;
    logic [HGT_W-1:0]   row_inc;
    logic               last_col;
    logic               last_row;
    napc_nbr_t          nbr;
    logic [PIX_W-1:0]   pix;
    logic [PIX_W-1:0]   result;

    // Position of the current pixel
    assign col_inc  = WID_W'(col_reg) + WID_W'(1);
    assign row_inc  = HGT_W'(row_reg) + HGT_W'(1);
    assign last_col = (col_inc == width_reg);
    assign last_row = (row_inc == height_reg);

    assign in_xfer = in_valid && !in_stall;
    assign cfg_hit = cfg_we && ((cfg_index == REG_MODE) || (cfg_index == REG_WIDTH)
                                || (cfg_index == REG_HEIGHT));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_READ_NE;
                end
            end
            ST_READ_NE:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: line store reads, input stall, result launch
    always_comb
    begin
        in_stall  = 1'b1;
        ram_re    = 1'b0;
        ram_raddr = col_reg;
        fire      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                ram_re    = in_valid;
                ram_raddr = col_reg;
            end
            ST_READ_NE:
            begin
                ram_re    = 1'b1;
                ram_raddr = COL_W'(col_inc);
            end
            ST_CALC:
            begin
                fire = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Neighbors present at this position
    always_comb
    begin
        nbr.has_n  = (row_reg != '0);
        nbr.has_nw = (row_reg != '0) && (col_reg != '0);
        nbr.has_ne = (row_reg != '0) && !last_col;
        nbr.has_w  = (col_reg != '0);
    end

    napc_pred u_pred (
        .nbr    (nbr),
        .nw     (nw_reg),
        .n      (n_reg),
        .ne     (ram_rdata),
        .w      (west_reg),
        .x      (x_reg),
        .mode   (mode_reg),
        .pix    (pix),
        .result (result)
    );

    napc_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (fire),
        .waddr (col_reg),
        .wdata (pix),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Advance the frame position and the west and north-west pixels
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        west_next = west_reg;
        nw_next   = nw_reg;
        if (cfg_hit)
        begin
            col_next  = '0;
            row_next  = '0;
            west_next = '0;
            nw_next   = '0;
        end
        else if (fire)
        begin
            if (last_col)
            begin
                col_next  = '0;
                row_next  = last_row ? '0 : ROW_W'(row_inc);
                west_next = '0;
                nw_next   = '0;
            end
            else
            begin
                col_next  = COL_W'(col_inc);
                west_next = pix;
                nw_next   = nbr.has_n ? n_reg : '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_RST;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            west_reg      <= '0;
            nw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            west_reg  <= west_next;
            nw_reg    <= nw_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_WIDTH:  width_reg  <= clamp_width(cfg_data);
                    REG_HEIGHT: height_reg <= clamp_height(cfg_data);
                    default:    mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg <= pixel_in;
        end
        if (state_reg == ST_READ_NE)
        begin
            n_reg <= ram_rdata;
        end
        if (fire)
        begin
            value_out_reg <= result;
            eof_reg       <= last_col && last_row;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value_out    = value_out_reg;
    assign end_of_frame = eof_reg;

    // Position stays inside the frame
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        WID_W'(col_reg) < width_reg)
        else $error("column position beyond image width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        HGT_W'(row_reg) < height_reg)
        else $error("row position beyond image height");

    // An accepted pixel goes on to its second read
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_READ_NE))
        else $error("accepted pixel did not advance to the north-east read");

    // A launched result shows up as valid next cycle
    a_fire_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("launched result not presented");

    // Line store never read and written in the same cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && ram_re))
        else $error("line store read overlaps write-back");

endmodule

// ===== hw/rtl/napc_ram.sv =====
`timescale 1ns / 1ps

module napc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/napc_pred.sv =====
`timescale 1ns / 1ps

module napc_pred (
    input  napc_pkg::napc_nbr_t          nbr,
    input  logic [napc_pkg::PIX_W-1:0]   nw,
    input  logic [napc_pkg::PIX_W-1:0]   n,
    input  logic [napc_pkg::PIX_W-1:0]   ne,
    input  logic [napc_pkg::PIX_W-1:0]   w,
    input  logic [napc_pkg::PIX_W-1:0]   x,
    input  logic                         mode,
    output logic [napc_pkg::PIX_W-1:0]   pix,
    output logic [napc_pkg::PIX_W-1:0]   result
);
    import napc_pkg::*;

    logic [SUM_W-1:0]      sum;
    logic [2:0]            count;
    logic [2*SUM_W-1:0]    prod3;
    logic [SUM_W-1:0]      pred;

    // Add the neighbors that exist
    always_comb
    begin
        sum = (nbr.has_nw ? SUM_W'(nw) : '0)
            + (nbr.has_n  ? SUM_W'(n)  : '0)
            + (nbr.has_ne ? SUM_W'(ne) : '0)
            + (nbr.has_w  ? SUM_W'(w)  : '0);
        count = 3'(nbr.has_nw) + 3'(nbr.has_n) + 3'(nbr.has_ne) + 3'(nbr.has_w);
    end

    // Divide by three through a reciprocal: exact for sums below 2048
    assign prod3 = sum * SUM_W'(683);

    // Truncated average
    always_comb
    begin
        unique case (count)
            3'd2:    pred = sum >> 1;
            3'd3:    pred = SUM_W'(prod3 >> 11);
            3'd4:    pred = sum >> 2;
            default: pred = sum;
        endcase
    end

    // Residual or reconstruction, mod 256
    always_comb
    begin
        if (mode == MODE_COMPRESS)
        begin
            pix    = x;
            result = x - PIX_W'(pred);
        end
        else
        begin
            pix    = PIX_W'(pred) + x;
            result = pix;
        end
    end

endmodule
